@@ hw/rtl/ofb_pkg.sv @@
package ofb_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int MAX_STEP      = 16;
	localparam int MAX_OVERLAP   = 4;
	localparam int HIST_DEPTH    = MAX_STEP * MAX_OVERLAP;
	localparam int ADDR_BITS     = $clog2(HIST_DEPTH);
	localparam int TOT_BITS      = ADDR_BITS + 1;
	localparam int STEP_BITS     = 5;
	localparam int OVL_BITS      = 3;
	localparam int PROD_BITS     = STEP_BITS + OVL_BITS;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 5;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_STEP    = 2'd0,
		REG_OVERLAP = 2'd1
	} cfg_reg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic emit_start;
		logic issue;
		logic finish;
	} ofb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic hop_done;
		logic can_issue;
		logic last_issue;
	} ofb_sts_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smp;
		logic [ADDR_BITS-1:0]          idx;
		logic                          lst;
	} ofb_res_t;

endpackage

@@ hw/rtl/ofb_ram.sv @@
module ofb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ofb_ctrl.sv @@
module ofb_ctrl import ofb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ofb_sts_t sts,
	output ofb_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EMIT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.hop_done) begin
						cmd.emit_start = 1'b1;
						state_nxt      = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (sts.can_issue) begin
					cmd.issue = 1'b1;
					if (sts.last_issue) begin
						state_nxt = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				// The last read returns and is written back in this cycle.
				cmd.finish = 1'b1;
				state_nxt  = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ hw/rtl/ofb_dp.sv @@
module ofb_dp import ofb_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_idx,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  ofb_cmd_t                      cmd,
	output ofb_sts_t                      sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ofb_res_t                      out_res
);

	logic [STEP_BITS-1:0] step_q, step_eff, fill_q, fill_eff, fill_inc;
	logic [OVL_BITS-1:0]  ovl_q, ovl_eff, ovl_m1;
	logic [TOT_BITS-1:0]  ring, total;
	logic [ADDR_BITS-1:0] oldest_q, oldest_eff, ptr_q, ptr_inc, k_q;
	logic [ADDR_BITS-1:0] rd_addr, in_addr;
	logic                 phase1;

	logic [HIST_DEPTH-1:0] valid_q;

	logic                   rd_vld_s1, wb_s1, hv_s1, last_s1;
	logic [ADDR_BITS-1:0]   idx_s1, wb_addr_s1;
	logic [SAMPLE_BITS-1:0] ram_rdata, rd_val, ram_wdata;
	logic [ADDR_BITS-1:0]   ram_waddr;
	logic                   ram_we;

	ofb_res_t q_mem [2];
	logic     q_wptr_q, q_rptr_q;
	logic [1:0] q_cnt_q, need;
	logic     push, pop;

	// Out-of-range register values are clamped to the legal range.
	always_comb begin
		if (step_q == '0) begin
			step_eff = STEP_BITS'(1);
		end else if (step_q > STEP_BITS'(MAX_STEP)) begin
			step_eff = STEP_BITS'(MAX_STEP);
		end else begin
			step_eff = step_q;
		end
		if (ovl_q == '0) begin
			ovl_eff = OVL_BITS'(1);
		end else if (ovl_q > OVL_BITS'(MAX_OVERLAP)) begin
			ovl_eff = OVL_BITS'(MAX_OVERLAP);
		end else begin
			ovl_eff = ovl_q;
		end
	end

	assign ovl_m1 = ovl_eff - OVL_BITS'(1);
	assign ring   = TOT_BITS'(PROD_BITS'(step_eff) * PROD_BITS'(ovl_m1));
	assign total  = ring + TOT_BITS'(step_eff);

	assign oldest_eff = (TOT_BITS'(oldest_q) >= ring) ? '0 : oldest_q;
	assign fill_eff   = (fill_q >= step_eff) ? '0 : fill_q;
	assign fill_inc   = fill_eff + STEP_BITS'(1);
	assign in_addr    = ADDR_BITS'(ring + TOT_BITS'(fill_eff));

	// Older hops are read through the ring pointer; the new hop sits at
	// addresses ring..total-1, which equal the frame index itself.
	assign phase1  = TOT_BITS'(k_q) < ring;
	assign rd_addr = phase1 ? ptr_q : k_q;

	always_comb begin
		if (ring == '0 || (TOT_BITS'(ptr_q) + TOT_BITS'(1)) == ring) begin
			ptr_inc = '0;
		end else begin
			ptr_inc = ptr_q + ADDR_BITS'(1);
		end
	end

	assign push = rd_vld_s1;
	assign pop  = out_valid & out_ready;
	assign need = q_cnt_q + {1'b0, rd_vld_s1};

	assign sts.hop_done   = (fill_inc == step_eff);
	assign sts.last_issue = (TOT_BITS'(k_q) == (total - TOT_BITS'(1)));
	assign sts.can_issue  = (need < 2'd2) || ((need == 2'd2) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_BITS'(MAX_STEP);
			ovl_q    <= OVL_BITS'(MAX_OVERLAP);
			fill_q   <= '0;
			oldest_q <= '0;
			ptr_q    <= '0;
			k_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_STEP: begin
						step_q   <= cfg_data[STEP_BITS-1:0];
						fill_q   <= '0;
						oldest_q <= '0;
					end
					REG_OVERLAP: begin
						ovl_q    <= cfg_data[OVL_BITS-1:0];
						fill_q   <= '0;
						oldest_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				fill_q <= sts.hop_done ? '0 : fill_inc;
			end
			if (cmd.emit_start) begin
				k_q   <= '0;
				ptr_q <= oldest_eff;
			end
			if (cmd.issue) begin
				k_q   <= k_q + ADDR_BITS'(1);
				ptr_q <= ptr_inc;
			end
			if (cmd.finish) begin
				oldest_q <= ptr_q;
			end
		end
	end

	// Read stage: the history word returns in the cycle after the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			wb_s1     <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.issue;
			wb_s1     <= cmd.issue && !phase1 && (ring != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			idx_s1     <= k_q;
			last_s1    <= sts.last_issue;
			hv_s1      <= valid_q[rd_addr];
			wb_addr_s1 <= ptr_q;
		end
	end

	// Entries never written since reset read as zero.
	assign rd_val = hv_s1 ? ram_rdata : '0;

	assign ram_we    = cmd.accept | wb_s1;
	assign ram_waddr = wb_s1 ? wb_addr_s1 : in_addr;
	assign ram_wdata = wb_s1 ? rd_val : sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	ofb_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.issue),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Two-entry output queue; reads are only issued when a slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wptr_q <= 1'b0;
			q_rptr_q <= 1'b0;
			q_cnt_q  <= '0;
		end else begin
			if (push) begin
				q_wptr_q <= ~q_wptr_q;
			end
			if (pop) begin
				q_rptr_q <= ~q_rptr_q;
			end
			q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[q_wptr_q] <= '{smp: rd_val, idx: idx_s1, lst: last_s1};
		end
	end

	assign out_valid = (q_cnt_q != '0);
	assign out_res   = q_mem[q_rptr_q];

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (q_cnt_q < 2'd2 || pop))
		else $error("output queue overflow");

	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.accept && wb_s1))
		else $error("sample write collides with ring write-back");

	a_no_read_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !rd_vld_s1)
		else $error("sample accepted while a history read is in flight");
`endif

endmodule

@@ hw/rtl/overlapping_frame_buffer_unit.sv @@
// Overlapping frame buffer.
// Samples enter on the in channel (in_valid/in_ready, one Q1.15 sample per
// beat) and are gathered into hops of step_length samples. The beat that
// completes a hop starts a frame of step_length * overlap_factor beats on the
// out channel: the older hops, oldest first, then the new hop; last marks
// the final beat and frame_index counts from zero.
// Registers are written on the cfg channel (index 0 step_length, index 1
// overlap_factor); the user must do so only while the block is idle, which
// the block does not enforce. A write to either register restarts the hop
// and keeps the history. cfg_ready is always high. After the completing
// sample, the emit state issues history reads whose words enter the output
// queue; beats follow one per cycle while the receiver keeps up, set by the
// single read port of the history RAM. A drain state then closes the frame.
// A two-beat output queue decouples the sides: when the receiver stalls,
// reads pause, and once the whole frame has been read new samples are
// accepted while the queue drains.
// After reset the history reads as zero, so early frames begin with zeros;
// no clearing pass is needed and input is accepted at once.
module overlapping_frame_buffer_unit import ofb_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] frame_sample,
	output logic [ADDR_BITS-1:0]          frame_index,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

	ofb_cmd_t cmd;
	ofb_sts_t sts;
	ofb_res_t res;

	assign cfg_ready = 1'b1;

	ofb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	ofb_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_idx  (cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (res)
	);

	assign frame_sample = res.smp;
	assign frame_index  = res.idx;
	assign last         = res.lst;

endmodule

@@ bench/overlapping_frame_buffer_unit_test.sv @@
`timescale 1ns / 1ps

module overlapping_frame_buffer_unit_test;
	import ofb_pkg::*;

	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned REPORT_CAP = 100;
	localparam logic [CFG_IDX_BITS-1:0] UNUSED_IDX_A = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] UNUSED_IDX_B = 2'd3;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] frame_sample;
	logic [ADDR_BITS-1:0] frame_index;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// Shadow copy of the block's registers and history.
	logic [STEP_BITS-1:0] step_reg = 5'd16;
	logic [OVL_BITS-1:0] ovl_reg = 3'd4;
	logic [SAMPLE_BITS-1:0] ring_mem [HIST_DEPTH];
	int unsigned oldest_slot = 0;
	int unsigned hop_count = 0;

	ofb_res_t frame_queue [$];
	int unsigned error_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	overlapping_frame_buffer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_sample(frame_sample),
		.frame_index(frame_index),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int unsigned eff_step_len();
		if (step_reg == 0) return 1;
		if (step_reg > MAX_STEP) return MAX_STEP;
		return step_reg;
	endfunction

	function automatic int unsigned eff_overlap();
		if (ovl_reg == 0) return 1;
		if (ovl_reg > MAX_OVERLAP) return MAX_OVERLAP;
		return ovl_reg;
	endfunction

	task automatic report_mismatch(input string msg);
		// Keep the log readable when the block is badly off.
		if (error_count < REPORT_CAP) $display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic predict_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		if (idx == REG_STEP) step_reg = val[STEP_BITS-1:0];
		else if (idx == REG_OVERLAP) ovl_reg = val[OVL_BITS-1:0];
		else return;
		hop_count = 0;
		oldest_slot = 0;
	endtask

	task automatic predict_frame(input logic [SAMPLE_BITS-1:0] s);
		int unsigned step_len;
		int unsigned ring;
		int unsigned total;
		int unsigned fill;
		int unsigned k;
		logic [SAMPLE_BITS-1:0] v;
		ofb_res_t beat;
		step_len = eff_step_len();
		ring = step_len * (eff_overlap() - 1);
		total = ring + step_len;
		fill = hop_count;
		if (fill >= step_len) fill = 0;
		if (oldest_slot >= ring) oldest_slot = 0;
		ring_mem[(ring + fill) % HIST_DEPTH] = s;
		fill++;
		if (fill < step_len) begin
			hop_count = fill;
			return;
		end
		k = 0;
		// Older hops go out first, starting from the oldest slot of the ring.
		for (int unsigned i = 0; i < ring; i++) begin
			beat.smp = ring_mem[(oldest_slot + i) % ring];
			beat.idx = k[ADDR_BITS-1:0];
			beat.lst = (k + 1 == total);
			frame_queue.push_back(beat);
			k++;
		end
		// The new hop follows and takes the place of the oldest hop.
		for (int unsigned i = 0; i < step_len; i++) begin
			v = ring_mem[(ring + i) % HIST_DEPTH];
			beat.smp = v;
			beat.idx = k[ADDR_BITS-1:0];
			beat.lst = (k + 1 == total);
			frame_queue.push_back(beat);
			k++;
			if (ring > 0) ring_mem[(oldest_slot + i) % ring] = v;
		end
		if (ring > 0) oldest_slot = (oldest_slot + step_len) % ring;
		hop_count = 0;
	endtask

	always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin : check_beats
		ofb_res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (frame_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, index %0d sample %0d",
					frame_index, frame_sample));
			end else begin
				want = frame_queue.pop_front();
				if (frame_sample !== want.smp)
					report_mismatch($sformatf("frame_sample at index %0d: got %0d, expected %0d",
						want.idx, frame_sample, want.smp));
				if (frame_index !== want.idx)
					report_mismatch($sformatf("frame_index: got %0d, expected %0d",
						frame_index, want.idx));
				if (last !== want.lst)
					report_mismatch($sformatf("last at index %0d: got %0b, expected %0b",
						want.idx, last, want.lst));
			end
		end
	end

	// Called at a falling edge. Valid is left high so that the next beat can
	// follow without a gap; whoever comes next either reloads or lowers it.
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_frame(s);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		predict_reg_write(idx, val);
		@(negedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_BITS-1:0] step_val,
			input logic [CFG_DATA_BITS-1:0] ovl_val);
		write_reg(REG_STEP, step_val);
		write_reg(REG_OVERLAP, ovl_val);
		cfg_valid <= 1'b0;
	endtask

	// The block may still be storing a sample that produced no beat, so the
	// queue running empty is followed by a short hold-off.
	task automatic wait_frames_drained();
		in_valid <= 1'b0;
		while (frame_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(15))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_BITS-1:0] random_step();
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 5'd0 : CFG_DATA_BITS'($urandom_range(31, 17));
			1, 2: return CFG_DATA_BITS'($urandom_range(16, 6));
			default: return CFG_DATA_BITS'($urandom_range(5, 1));
		endcase
	endfunction

	task automatic run_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
			input int unsigned n_items, input logic [CFG_DATA_BITS-1:0] first_step,
			input logic [CFG_DATA_BITS-1:0] first_ovl);
		int unsigned sent;
		int unsigned count;
		int unsigned step_len;
		bit first;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		first = 1'b1;
		while (sent < n_items) begin
			wait_frames_drained();
			if (first) configure(first_step, first_ovl);
			else configure(random_step(), CFG_DATA_BITS'($urandom_range(31)));
			first = 1'b0;
			if ($urandom_range(7) == 0) begin
				write_reg($urandom_range(1) ? UNUSED_IDX_A : UNUSED_IDX_B,
					CFG_DATA_BITS'($urandom_range(31)));
				cfg_valid <= 1'b0;
			end
			step_len = eff_step_len();
			count = step_len * ((step_len > 8) ? 1 : $urandom_range(4, 1));
			// Now and then leave a hop unfinished so the next write cuts it off.
			if ($urandom_range(3) == 0) count += $urandom_range(step_len - 1, 0);
			for (int unsigned i = 0; i < count; i++) begin
				send_sample(random_sample());
				sent++;
				if ($urandom_range(19) == 0) wait_frames_drained();
			end
		end
		wait_frames_drained();
	endtask

	task automatic test_reset_frame();
		logic [SAMPLE_BITS-1:0] pattern [8];
		pattern[0] = 16'h7fff;
		pattern[1] = 16'h8000;
		pattern[2] = 16'h0000;
		pattern[3] = 16'hffff;
		pattern[4] = 16'h5555;
		pattern[5] = 16'haaaa;
		pattern[6] = 16'h0001;
		pattern[7] = 16'hfffe;
		// Default registers: the first frame is three hops of zeros and the new hop.
		for (int i = 0; i < 16; i++) send_sample((i < 8) ? pattern[i] : random_sample());
		wait_frames_drained();
	endtask

	task automatic test_no_overlap_low_clamp();
		// Zero in both registers acts as one: each sample is a frame of one beat.
		configure(5'd0, 5'd0);
		send_sample(16'h7fff);
		send_sample(16'h8000);
		wait_frames_drained();
	endtask

	task automatic test_ring_rotation();
		// The upper data bits are dropped for the overlap register.
		configure(5'd2, 5'b11010);
		for (int i = 0; i < 4; i++) send_sample(random_sample());
		wait_frames_drained();
	endtask

	task automatic test_hop_restart();
		send_sample(16'h1234);
		wait_frames_drained();
		// Writes to unused indexes must not restart the hop.
		write_reg(UNUSED_IDX_A, 5'b10101);
		write_reg(UNUSED_IDX_B, 5'b01010);
		cfg_valid <= 1'b0;
		send_sample(16'hedcb);
		send_sample(16'h4321);
		wait_frames_drained();
		write_reg(REG_STEP, 5'd2);
		cfg_valid <= 1'b0;
		send_sample(random_sample());
		send_sample(random_sample());
		wait_frames_drained();
	endtask

	task automatic test_random_slow_receiver();
		run_random_traffic(16, 69, 60, 5'd31, 5'b11111);
	endtask

	task automatic test_random_slow_sender();
		run_random_traffic(69, 16, 60, 5'd17, 5'b01100);
	endtask

	task automatic test_random_back_to_back();
		run_random_traffic(0, 0, 60, 5'd1, 5'b00001);
	endtask

	initial begin
		foreach (ring_mem[i]) ring_mem[i] = '0;
		send_idle_pct = 16;
		recv_idle_pct = 69;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_reset_frame();
		test_no_overlap_low_clamp();
		test_ring_rotation();
		test_hop_restart();
		test_random_slow_receiver();
		test_random_slow_sender();
		test_random_back_to_back();
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d beats still expected", frame_queue.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
